>>> rtl/core/fdem_pkg.sv
// ----------------------------------------------------------------------------
// fdem_pkg
// shared types and constants of the forward difference edge map
// ----------------------------------------------------------------------------
package fdem_pkg;

   localparam int CFG_BITS     = 11;
   localparam int CSR_IDX_BITS = 2;
   localparam int DIM_BITS     = 12;
   localparam int POS_BITS     = 10;
   localparam int OUT_BITS     = 9;

   typedef enum logic [1:0] {
      CHAN_RED   = 2'd0,
      CHAN_GREEN = 2'd1,
      CHAN_BLUE  = 2'd2,
      CHAN_NONE  = 2'd3
   } chan_sel_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_CHANNEL_SELECT = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] width_last;
      logic [DIM_BITS-1:0] height_last;
      chan_sel_type        sel;
      logic                restart;
   } cfg_type;

endpackage

>>> rtl/core/fdem_if.sv
// ----------------------------------------------------------------------------
// fdem_req_if / fdem_rsp_if
// valid/ready channels for pixel requests and edge map responses
// ----------------------------------------------------------------------------
interface fdem_req_if #(
   parameter int SAMPLE_BITS = 8
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] chan_zero_in;
   logic [SAMPLE_BITS-1:0] chan_one_in;
   logic [SAMPLE_BITS-1:0] chan_two_in;

   modport source (output valid, chan_zero_in, chan_one_in, chan_two_in, input ready);
   modport sink (input valid, chan_zero_in, chan_one_in, chan_two_in, output ready);
endinterface

interface fdem_rsp_if;
   import fdem_pkg::*;

   logic                valid;
   logic                ready;
   logic [POS_BITS-1:0] out_row;
   logic [POS_BITS-1:0] out_column;
   logic [OUT_BITS-1:0] chan_zero_out;
   logic [OUT_BITS-1:0] chan_one_out;
   logic [OUT_BITS-1:0] chan_two_out;
   logic                last_of_step;
   logic                end_of_frame;

   modport source (output valid, out_row, out_column, chan_zero_out, chan_one_out,
                   chan_two_out, last_of_step, end_of_frame, input ready);
   modport sink (input valid, out_row, out_column, chan_zero_out, chan_one_out,
                 chan_two_out, last_of_step, end_of_frame, output ready);
endinterface

>>> rtl/core/fdem_csr.sv
// ----------------------------------------------------------------------------
// fdem_csr
// configuration registers, effective geometry and frame restart
// ----------------------------------------------------------------------------
module fdem_csr #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fdem_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [fdem_pkg::CFG_BITS-1:0]       csr_wdata,
   output fdem_pkg::cfg_type                   cfg
);
   import fdem_pkg::*;

   localparam logic [DIM_BITS:0] MaxW = (DIM_BITS+1)'(MAX_WIDTH);
   localparam logic [DIM_BITS:0] MaxH = (DIM_BITS+1)'(MAX_HEIGHT);
   localparam logic [DIM_BITS-1:0] ResetWLast =
      DIM_BITS'(((MAX_WIDTH < 640) ? MAX_WIDTH : 640) - 1);
   localparam logic [DIM_BITS-1:0] ResetHLast =
      DIM_BITS'(((MAX_HEIGHT < 480) ? MAX_HEIGHT : 480) - 1);

   logic [DIM_BITS-1:0] width_last_ff, width_last_in;
   logic [DIM_BITS-1:0] height_last_ff, height_last_in;
   chan_sel_type        sel_ff, sel_in;
   logic                restart;

   function automatic logic [DIM_BITS-1:0] eff_last(
      input logic [CFG_BITS-1:0] v,
      input logic [DIM_BITS:0]   maxv
   );
      logic [DIM_BITS:0] vw;
      logic [DIM_BITS:0] res;
      vw = (DIM_BITS+1)'(v);
      if (vw == '0) begin
         res = '0;
      end else if (vw > maxv) begin
         res = maxv - 1'b1;
      end else begin
         res = vw - 1'b1;
      end
      return res[DIM_BITS-1:0];
   endfunction

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      sel_in         = sel_ff;
      restart        = 1'b0;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               width_last_in = eff_last(csr_wdata, MaxW);
               restart       = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_last_in = eff_last(csr_wdata, MaxH);
               restart        = 1'b1;
            end
            CSR_CHANNEL_SELECT: begin
               sel_in = chan_sel_type'(csr_wdata[1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= ResetWLast;
         height_last_ff <= ResetHLast;
         sel_ff         <= CHAN_RED;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         sel_ff         <= sel_in;
      end
   end

   assign cfg.width_last  = width_last_ff;
   assign cfg.height_last = height_last_ff;
   assign cfg.sel         = sel_ff;
   assign cfg.restart     = restart;

endmodule

>>> rtl/core/fdem_line_mem.sv
// ----------------------------------------------------------------------------
// fdem_line_mem
// line store, one write and one registered read port
// ----------------------------------------------------------------------------
module fdem_line_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/fdem_core.sv
// ----------------------------------------------------------------------------
// fdem_core
// raster counters, line store access, gradient stage and two-result output
// ----------------------------------------------------------------------------
module fdem_core #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 1024,
   parameter int SAMPLE_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fdem_pkg::cfg_type                cfg,
   fdem_req_if.sink                         req_chan,
   fdem_rsp_if.source                       rsp_chan,
   output logic                             mem_we,
   output logic [$clog2(MAX_WIDTH)-1:0]     mem_waddr,
   output logic [3*SAMPLE_BITS-1:0]         mem_wdata,
   output logic                             mem_re,
   output logic [$clog2(MAX_WIDTH)-1:0]     mem_raddr,
   input  logic [3*SAMPLE_BITS-1:0]         mem_rdata
);
   import fdem_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SB = SAMPLE_BITS;
   localparam int PW = 3 * SAMPLE_BITS;
   localparam int GW = SAMPLE_BITS + 1;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          last_col, last_row, accept;
   logic [PW-1:0] cur;
   logic [PW-1:0] col0_ff;

   logic          p_valid_ff, p_valid_in;
   logic [RW-1:0] p_row_ff;
   logic [CW-1:0] p_col_ff;
   logic [PW-1:0] p_cur_ff, p_here0_ff, prev_right_ff;
   chan_sel_type  p_sel_ff;
   logic          p_last_col_ff, p_last_row_ff, p_has_above_ff;
   logic          p_needs_out, p_move;

   logic [PW-1:0] here;
   logic [SB-1:0] s_cur, s_here, s_right, d_down, d_right;
   logic [GW-1:0] grad;
   logic [GW-1:0] above [3];

   logic          o_valid_ff, o_valid_in;
   logic          o_phase_ff, o_phase_in;
   logic [RW-1:0] o_row_ff;
   logic [CW-1:0] o_col_ff;
   logic [GW-1:0] o_above_ff [3];
   logic [PW-1:0] o_cur_ff;
   logic          o_has_above_ff, o_has_cur_ff, o_last_col_ff;
   logic          o_show_above, o_take, o_done, o_free, o_load;

   logic [RW-1:0]          pos_row;
   logic [POS_BITS+RW-1:0] row_wide;
   logic [POS_BITS+CW-1:0] col_wide;
   logic [OUT_BITS+GW-1:0] chan_wide [3];

   // input side and raster position
   assign cur      = {req_chan.chan_two_in, req_chan.chan_one_in, req_chan.chan_zero_in};
   assign last_col = (col_ff == cfg.width_last[CW-1:0]);
   assign last_row = (row_ff == cfg.height_last[RW-1:0]);
   assign accept   = req_chan.valid && req_chan.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // line store: write current pixel, fetch the right neighbor of the row above
   assign mem_we    = accept;
   assign mem_waddr = col_ff;
   assign mem_wdata = cur;
   assign mem_re    = accept;
   assign mem_raddr = col_ff + 1'b1;

   // gradient stage
   assign here = (p_col_ff == '0) ? p_here0_ff : prev_right_ff;

   always_comb begin
      unique case (p_sel_ff)
         CHAN_RED: begin
            s_cur   = p_cur_ff[SB-1:0];
            s_here  = here[SB-1:0];
            s_right = mem_rdata[SB-1:0];
         end
         CHAN_GREEN: begin
            s_cur   = p_cur_ff[2*SB-1:SB];
            s_here  = here[2*SB-1:SB];
            s_right = mem_rdata[2*SB-1:SB];
         end
         CHAN_BLUE: begin
            s_cur   = p_cur_ff[3*SB-1:2*SB];
            s_here  = here[3*SB-1:2*SB];
            s_right = mem_rdata[3*SB-1:2*SB];
         end
         CHAN_NONE: begin
            s_cur   = '0;
            s_here  = '0;
            s_right = '0;
         end
      endcase
   end

   assign d_down  = (s_cur > s_here) ? s_cur - s_here : s_here - s_cur;
   assign d_right = (s_right > s_here) ? s_right - s_here : s_here - s_right;
   assign grad    = {1'b0, d_down} + {1'b0, d_right};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         above[k] = {1'b0, here[k*SB +: SB]};
         if (p_sel_ff != CHAN_NONE && !p_last_col_ff && k == int'(p_sel_ff)) begin
            above[k] = grad;
         end
      end
   end

   // pipeline handshake
   assign o_show_above = o_has_above_ff && !o_phase_ff;
   assign o_take       = o_valid_ff && rsp_chan.ready;
   assign o_done       = o_take && !(o_show_above && o_has_cur_ff);
   assign o_free       = !o_valid_ff || o_done;
   assign p_needs_out  = p_has_above_ff || p_last_row_ff;
   assign p_move       = p_valid_ff && (!p_needs_out || o_free);
   assign o_load       = p_move && p_needs_out;
   assign req_chan.ready = !p_valid_ff || p_move;

   always_comb begin
      p_valid_in = p_valid_ff;
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (p_move) begin
         p_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff;
      if (o_load) begin
         o_valid_in = 1'b1;
      end else if (o_done) begin
         o_valid_in = 1'b0;
      end
      o_phase_in = o_phase_ff;
      if (o_load) begin
         o_phase_in = 1'b0;
      end else if (o_take && o_show_above && o_has_cur_ff) begin
         o_phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         o_phase_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
         o_phase_ff <= o_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && col_ff == '0) begin
         col0_ff <= cur;
      end
      if (accept) begin
         p_row_ff       <= row_ff;
         p_col_ff       <= col_ff;
         p_cur_ff       <= cur;
         p_here0_ff     <= col0_ff;
         p_sel_ff       <= cfg.sel;
         p_last_col_ff  <= last_col;
         p_last_row_ff  <= last_row;
         p_has_above_ff <= (row_ff != '0);
      end
      if (p_move) begin
         prev_right_ff <= mem_rdata;
      end
      if (o_load) begin
         o_row_ff       <= p_row_ff;
         o_col_ff       <= p_col_ff;
         o_above_ff     <= above;
         o_cur_ff       <= p_cur_ff;
         o_has_above_ff <= p_has_above_ff;
         o_has_cur_ff   <= p_last_row_ff;
         o_last_col_ff  <= p_last_col_ff;
      end
   end

   // response fields
   assign pos_row  = o_show_above ? o_row_ff - 1'b1 : o_row_ff;
   assign row_wide = {{POS_BITS{1'b0}}, pos_row};
   assign col_wide = {{POS_BITS{1'b0}}, o_col_ff};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         chan_wide[k] = o_show_above ? {{OUT_BITS{1'b0}}, o_above_ff[k]}
                                     : {{OUT_BITS{1'b0}}, 1'b0, o_cur_ff[k*SB +: SB]};
      end
   end

   assign rsp_chan.valid         = o_valid_ff;
   assign rsp_chan.out_row       = row_wide[POS_BITS-1:0];
   assign rsp_chan.out_column    = col_wide[POS_BITS-1:0];
   assign rsp_chan.chan_zero_out = chan_wide[0][OUT_BITS-1:0];
   assign rsp_chan.chan_one_out  = chan_wide[1][OUT_BITS-1:0];
   assign rsp_chan.chan_two_out  = chan_wide[2][OUT_BITS-1:0];
   assign rsp_chan.last_of_step  = o_show_above ? !o_has_cur_ff : 1'b1;
   assign rsp_chan.end_of_frame  = o_show_above ? 1'b0 : o_last_col_ff;

   a_above_row_nonzero: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && o_show_above |-> o_row_ff != '0)
      else $error("row above emitted from the first row");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= cfg.width_last[CW-1:0])
      else $error("column counter beyond image width");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !p_move |-> !req_chan.ready)
      else $error("request taken while gradient stage is stalled");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !p_move |=> p_valid_ff && $stable(p_col_ff) && $stable(p_row_ff))
      else $error("stalled gradient stage lost its transaction");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_frame |-> rsp_chan.last_of_step)
      else $error("end of frame on a non-final response");

endmodule

>>> rtl/core/forward_difference_edge_map.sv
// ----------------------------------------------------------------------------
// forward_difference_edge_map
// latency: a request passes the gradient stage register and then the output
// register before its first response is valid
// throughput: 1 pixel per cycle unless rsp stalls; on the last row (of an image
// with two or more rows) 2 responses per pixel slow the input (single rsp port)
// reset: counters and config to defaults, line store left unset (no sweep)
// ----------------------------------------------------------------------------
module forward_difference_edge_map #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 1024,
   parameter int SAMPLE_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fdem_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [fdem_pkg::CFG_BITS-1:0]     csr_wdata,
   fdem_req_if.sink                          req_chan,
   fdem_rsp_if.source                        rsp_chan
);
   import fdem_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int PW = 3 * SAMPLE_BITS;

   cfg_type       cfg;
   logic          mem_we, mem_re;
   logic [CW-1:0] mem_waddr, mem_raddr;
   logic [PW-1:0] mem_wdata, mem_rdata;

   fdem_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fdem_line_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   fdem_core #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

>>> verif/fdem_checker.sv
// ----------------------------------------------------------------------------
// fdem_checker
// watches the csr port and both channels of the forward difference edge map,
// keeps its own line store and row/column position, predicts the edge pixels
// caused by each accepted pixel and compares them field by field, in order,
// with the responses the block hands over
// ----------------------------------------------------------------------------
module fdem_checker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fdem_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [fdem_pkg::CFG_BITS-1:0]     csr_wdata,
   fdem_req_if                               req_chan,
   fdem_rsp_if                               rsp_chan,
   output int                                mismatch_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fdem_pkg::*;

   typedef struct packed {
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] column;
      logic [OUT_BITS-1:0] zero;
      logic [OUT_BITS-1:0] one;
      logic [OUT_BITS-1:0] two;
      logic                last_of_step;
      logic                end_of_frame;
   } edge_pixel_type;

   logic [CFG_BITS-1:0] width_reg;
   logic [CFG_BITS-1:0] height_reg;
   chan_sel_type        sel_reg;
   logic [7:0]          line_store [MAX_WIDTH][3];
   int                  row_pos;
   int                  col_pos;
   edge_pixel_type      expected_pixels [$];

   function automatic edge_pixel_type edge_pixel(int row, int col, int v [3], bit last,
                                                 bit eof);
      edge_pixel_type p;
      p.row          = POS_BITS'(row);
      p.column       = POS_BITS'(col);
      p.zero         = OUT_BITS'(v[0]);
      p.one          = OUT_BITS'(v[1]);
      p.two          = OUT_BITS'(v[2]);
      p.last_of_step = last;
      p.end_of_frame = eof;
      return p;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      int             w;
      int             h;
      int             s;
      int             here;
      int             right;
      int             cur [3];
      int             v [3];
      bit             last_col;
      bit             last_row;
      edge_pixel_type got;
      edge_pixel_type want;
      if (reset) begin
         width_reg  = CFG_BITS'(640);
         height_reg = CFG_BITS'(480);
         sel_reg    = CHAN_RED;
         row_pos    = 0;
         col_pos    = 0;
         expected_pixels.delete();
         foreach (line_store[i, k]) line_store[i][k] = 8'd0;
      end else begin
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               CSR_IMAGE_WIDTH: begin
                  width_reg = csr_wdata;
                  row_pos   = 0;
                  col_pos   = 0;
               end
               CSR_IMAGE_HEIGHT: begin
                  height_reg = csr_wdata;
                  row_pos    = 0;
                  col_pos    = 0;
               end
               CSR_CHANNEL_SELECT: begin
                  sel_reg = chan_sel_type'(csr_wdata[1:0]);
               end
               default: ;
            endcase
         end

         if (req_chan.valid && req_chan.ready) begin
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
            h = (height_reg == 0) ? 1 :
                (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
            cur[0]   = int'(req_chan.chan_zero_in);
            cur[1]   = int'(req_chan.chan_one_in);
            cur[2]   = int'(req_chan.chan_two_in);
            last_col = (col_pos + 1 >= w);
            last_row = (row_pos + 1 >= h);
            // row above is emitted while this row arrives
            if (row_pos >= 1) begin
               for (int k = 0; k < 3; k++) v[k] = int'(line_store[col_pos][k]);
               if (sel_reg != CHAN_NONE && !last_col) begin
                  s     = int'(sel_reg);
                  here  = int'(line_store[col_pos][s]);
                  right = int'(line_store[col_pos + 1][s]);
                  v[s]  = ((cur[s] > here) ? cur[s] - here : here - cur[s]) +
                          ((right > here) ? right - here : here - right);
               end
               expected_pixels.push_back(edge_pixel(row_pos - 1, col_pos, v, !last_row, 1'b0));
            end
            if (last_row) begin
               expected_pixels.push_back(edge_pixel(row_pos, col_pos, cur, 1'b1, last_col));
            end
            for (int k = 0; k < 3; k++) line_store[col_pos][k] = 8'(cur[k]);
            if (last_col) begin
               col_pos = 0;
               row_pos = last_row ? 0 : row_pos + 1;
            end else begin
               col_pos = col_pos + 1;
            end
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            got.row          = rsp_chan.out_row;
            got.column       = rsp_chan.out_column;
            got.zero         = rsp_chan.chan_zero_out;
            got.one          = rsp_chan.chan_one_out;
            got.two          = rsp_chan.chan_two_out;
            got.last_of_step = rsp_chan.last_of_step;
            got.end_of_frame = rsp_chan.end_of_frame;
            if (expected_pixels.size() == 0) begin
               $error("unexpected transaction at row %0d column %0d", got.row, got.column);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("out_row", want.row, got.row);
               check_field("out_column", want.column, got.column);
               check_field("chan_zero_out", want.zero, got.zero);
               check_field("chan_one_out", want.one, got.one);
               check_field("chan_two_out", want.two, got.two);
               check_field("last_of_step", want.last_of_step, got.last_of_step);
               check_field("end_of_frame", want.end_of_frame, got.end_of_frame);
            end
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the forward difference edge map: a directed set of
// small images with extreme samples, every channel select, zero and saturated
// geometry and a select change mid-frame, then random images and broken frames
// with random stalls on both channels; checking is done by fdem_checker
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fdem_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PIXELS = 550;
   localparam int DRAIN_CYCLES  = 6;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   csr_reg_type         csr_index;
   logic [CFG_BITS-1:0] csr_wdata;
   int                  mismatch_count;
   int                  pending_count;
   int                  pixel_count;
   int                  setup_count;
   int                  idle_cycles;
   int                  rsp_stall;
   bit                  req_steady;
   bit                  rsp_steady;

   fdem_req_if #(.SAMPLE_BITS(8)) req_chan();
   fdem_rsp_if                    rsp_chan();

   forward_difference_edge_map u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   fdem_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 8'h00;
      if (r < 16) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!rsp_steady) rsp_stall = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_pixel(input logic [7:0] zero, input logic [7:0] one,
                             input logic [7:0] two);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.chan_zero_in <= zero;
      req_chan.chan_one_in  <= one;
      req_chan.chan_two_in  <= two;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      pixel_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_image(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                            input chan_sel_type sel);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_index <= CSR_CHANNEL_SELECT;
      csr_wdata <= CFG_BITS'(sel);
      @(negedge clock);
      csr_we <= 1'b0;
      setup_count++;
   endtask

   task automatic write_select(input chan_sel_type sel);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_CHANNEL_SELECT;
      csr_wdata <= CFG_BITS'(sel);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_pixels(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(39) == 0) wait_drained();
         if ($urandom_range(99) < 3) write_select(chan_sel_type'($urandom_range(3)));
         send_pixel(pick_sample(), pick_sample(), pick_sample());
      end
   endtask

   initial begin
      int                  r;
      int                  weff;
      int                  heff;
      int                  area;
      int                  count;
      int                  goal;
      logic [CFG_BITS-1:0] w;
      logic [CFG_BITS-1:0] h;

      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_IMAGE_WIDTH;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.chan_zero_in = '0;
      req_chan.chan_one_in  = '0;
      req_chan.chan_two_in  = '0;
      rsp_steady            = 1'b0;
      req_steady            = 1'b0;
      pixel_count           = 0;
      setup_count           = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full-scale gradient, sum reaches 510
      set_image(11'd3, 11'd2, CHAN_RED);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      // width one with selector none
      set_image(11'd1, 11'd3, CHAN_NONE);
      send_pixel(8'hFF, 8'h00, 8'hAA);
      send_pixel(8'h00, 8'hFF, 8'h55);
      send_pixel(8'h5A, 8'hA5, 8'hFF);
      // one-row image
      set_image(11'd4, 11'd1, CHAN_GREEN);
      send_pixel(8'h01, 8'hFE, 8'h80);
      send_pixel(8'h7F, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'h80, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h7F);
      // zero geometry acts as one by one
      set_image(11'd0, 11'd0, CHAN_BLUE);
      send_pixel(8'hC3, 8'h3C, 8'hFF);
      // oversized geometry saturates, frame abandoned early
      set_image(11'h7FF, 11'h7FF, CHAN_BLUE);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h12, 8'h34, 8'h56);
      // select change in the middle of a frame
      set_image(11'd2, 11'd3, CHAN_RED);
      send_pixel(8'h10, 8'h20, 8'h30);
      send_pixel(8'hF0, 8'hE0, 8'hD0);
      write_select(CHAN_BLUE);
      send_pixel(8'h00, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h40, 8'h80, 8'hC0);
      send_pixel(8'hC0, 8'h80, 8'h40);

      goal = pixel_count + RANDOM_PIXELS;
      while (pixel_count < goal) begin
         r = $urandom_range(99);
         if (r < 80) w = CFG_BITS'($urandom_range(1, 12));
         else if (r < 92) w = CFG_BITS'($urandom_range(13, 64));
         else w = ($urandom_range(1) == 0) ? '0 : CFG_BITS'($urandom_range(1024, 2047));
         r = $urandom_range(99);
         if (r < 80) h = CFG_BITS'($urandom_range(1, 8));
         else if (r < 92) h = CFG_BITS'($urandom_range(9, 24));
         else h = ($urandom_range(1) == 0) ? '0 : CFG_BITS'($urandom_range(1024, 2047));
         weff = (w == 0) ? 1 : (w > 1024) ? 1024 : int'(w);
         heff = (h == 0) ? 1 : (h > 1024) ? 1024 : int'(h);
         area = weff * heff;
         req_steady = ($urandom_range(3) == 0);
         rsp_steady = ($urandom_range(3) == 0);
         set_image(w, h, chan_sel_type'($urandom_range(3)));
         if (area <= 60) count = area * $urandom_range(1, 3);
         else if (area <= 300) count = area;
         else count = 0;
         // trailing broken frame, cut off by the next geometry write
         if (count == 0 || $urandom_range(3) == 0) begin
            count += $urandom_range(1, (area < 40) ? area : 40);
         end
         if (count > goal - pixel_count) count = goal - pixel_count;
         send_random_pixels(count);
      end

      req_steady = 1'b0;
      rsp_steady = 1'b0;
      wait_drained();
      repeat (10) @(negedge clock);
      $display("tb: %0d pixels over %0d image setups, with random stalls on both channels",
               pixel_count, setup_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/fdem_pkg.sv
rtl/core/fdem_if.sv
rtl/core/fdem_csr.sv
rtl/core/fdem_line_mem.sv
rtl/core/fdem_core.sv
rtl/core/forward_difference_edge_map.sv
verif/fdem_checker.sv
verif/tb.sv
